@@ rtl/core/perceptron_train_classify_defines.svh @@
// Assertion macros shared by the perceptron block
`ifndef PERCEPTRON_TRAIN_CLASSIFY_DEFINES_SVH
`define PERCEPTRON_TRAIN_CLASSIFY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PTC_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("perceptron assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PTC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("perceptron assertion failed");

`endif

@@ rtl/core/ptc_pkg.sv @@
// Types, constants and helper functions of the perceptron block
package ptc_pkg;

    localparam int FEAT_W       = 16;
    localparam int WT_W         = 24;
    localparam int CNT_W        = 16;
    localparam int LR_W         = 16;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 4;
    localparam int MAX_FEATURES = 8;
    localparam int FRAC_BITS    = 14;
    localparam int STEP_SHIFT   = 30;
    localparam int SAT_IN_W     = 32;
    localparam int PROD_W       = FEAT_W + WT_W;
    localparam int P1_W         = FEAT_W + LR_W + 1;
    localparam int P2_W         = WT_W + P1_W;
    localparam int STEP_W       = P2_W - STEP_SHIFT;

    localparam logic [1:0] ACT_LINEAR   = 2'd0;
    localparam logic [1:0] ACT_UNIPOLAR = 2'd1;

    localparam logic [1:0]       RST_ACT_KIND   = 2'd1;
    localparam logic [WT_W-1:0]  RST_BIAS       = 24'd0;
    localparam logic [LR_W-1:0]  RST_LRATE      = 16'd1638;
    localparam logic [CNT_W-1:0] RST_MAX_EPOCHS = 16'd100;

    localparam logic signed [WT_W-1:0]     ONE_Q14 = 24'sd16384;
    localparam logic signed [SAT_IN_W-1:0] SAT_HI  = 32'sd8388607;
    localparam logic signed [SAT_IN_W-1:0] SAT_LO  = -32'sd8388608;
    localparam logic [CNT_W-1:0]           CNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_TRAIN,
        MODE_VERIFY,
        MODE_CLASSIFY,
        MODE_LOAD
    } mode_t;

    typedef enum logic [1:0] {
        REG_ACT_KIND,
        REG_BIAS,
        REG_LRATE,
        REG_MAX_EPOCHS
    } reg_idx_t;

    typedef logic signed [FEAT_W-1:0] feat_t;
    typedef logic signed [WT_W-1:0]   wt_t;
    typedef feat_t feat_vec_t [MAX_FEATURES];

    typedef struct packed {
        logic [1:0]       act_kind;
        wt_t              bias;
        logic [LR_W-1:0]  lrate;
        logic [CNT_W-1:0] max_epochs;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic dot_issue;
        logic act;
        logic upd_issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  refuse;
    } stat_t;

    typedef struct packed {
        wt_t              guess;
        wt_t              error;
        logic             correct;
        logic [CNT_W-1:0] ccount;
        logic [CNT_W-1:0] wcount;
        logic             refused;
    } res_t;

    function automatic wt_t sat24(input logic signed [SAT_IN_W-1:0] x);
        wt_t r;
        if (x > SAT_HI)
            r = SAT_HI[WT_W-1:0];
        else if (x < SAT_LO)
            r = SAT_LO[WT_W-1:0];
        else
            r = x[WT_W-1:0];
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == CNT_MAX)
            r = c;
        else
            r = c + 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/core/ptc_cfg.sv @@
// APB configuration registers of the perceptron block
module ptc_cfg
    import ptc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    reg_idx_t         reg_idx;
    logic             wr_en;
    logic [1:0]       act_kind_reg;
    wt_t              bias_reg;
    logic [LR_W-1:0]  lrate_reg;
    logic [CNT_W-1:0] max_epochs_reg;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_kind_reg   <= RST_ACT_KIND;
            bias_reg       <= RST_BIAS;
            lrate_reg      <= RST_LRATE;
            max_epochs_reg <= RST_MAX_EPOCHS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ACT_KIND:   act_kind_reg   <= pwdata[1:0];
                REG_BIAS:       bias_reg       <= pwdata[WT_W-1:0];
                REG_LRATE:      lrate_reg      <= pwdata[LR_W-1:0];
                REG_MAX_EPOCHS: max_epochs_reg <= pwdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACT_KIND:   prdata = DATA_W'(act_kind_reg);
            REG_BIAS:       prdata = DATA_W'(bias_reg);
            REG_LRATE:      prdata = DATA_W'(lrate_reg);
            REG_MAX_EPOCHS: prdata = DATA_W'(max_epochs_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.act_kind   = act_kind_reg;
    assign cfg.bias       = bias_reg;
    assign cfg.lrate      = lrate_reg;
    assign cfg.max_epochs = max_epochs_reg;

endmodule

@@ rtl/core/ptc_ctrl.sv @@
// Sequencing state machine of the perceptron block
module ptc_ctrl
    import ptc_pkg::*;
#(
    parameter int NUM_FEATURES = 8,
    localparam int IW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  stat_t         stat,
    output cmd_t          cmd,
    output logic [IW-1:0] idx
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_DOT,
        S_DOT_DRAIN,
        S_ACT,
        S_UPD,
        S_UPD_DRAIN1,
        S_UPD_DRAIN2,
        S_FIN
    } state_t;

    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FEATURES - 1);

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          fin_go;

    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                idx_next = '0;
                if (stat.mode == MODE_LOAD || stat.refuse)
                    state_next = S_FIN;
                else
                    state_next = S_DOT;
            end
            S_DOT:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = S_DOT_DRAIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_DOT_DRAIN:
                state_next = S_ACT;
            S_ACT:
            begin
                idx_next = '0;
                if (stat.mode == MODE_TRAIN)
                    state_next = S_UPD;
                else
                    state_next = S_FIN;
            end
            S_UPD:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = S_UPD_DRAIN1;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_UPD_DRAIN1:
                state_next = S_UPD_DRAIN2;
            S_UPD_DRAIN2:
                state_next = S_FIN;
            S_FIN:
            begin
                if (fin_go)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (fin_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign idx           = idx_reg;
    assign cmd.capture   = in_ready & in_valid;
    assign cmd.dot_issue = (state_reg == S_DOT);
    assign cmd.act       = (state_reg == S_ACT);
    assign cmd.upd_issue = (state_reg == S_UPD);
    assign cmd.finish    = fin_go;

endmodule

@@ rtl/core/ptc_dpath.sv @@
// Weight store, shared multipliers, activation and tallies of the perceptron block
module ptc_dpath
    import ptc_pkg::*;
#(
    parameter int NUM_FEATURES = 8,
    localparam int IW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  cmd_t          cmd,
    input  logic [IW-1:0] idx,
    input  logic [1:0]    mode,
    input  feat_vec_t     feat_in,
    input  feat_t         target_value,
    input  logic          last_sample,
    output stat_t         stat,
    output res_t          res
);

    localparam int ACC_W = PROD_W + $clog2(NUM_FEATURES);
    localparam int SHR_W = ACC_W - FRAC_BITS;

    mode_t                    mode_reg;
    logic                     last_reg;
    feat_t                    target_reg;
    feat_t                    x_reg [NUM_FEATURES];
    wt_t                      w_reg [NUM_FEATURES];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    wt_t                      guess_reg, err_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic [IW-1:0]            i1_reg;
    logic                     v1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic [IW-1:0]            i2_reg;
    logic                     v2_reg;
    logic [CNT_W-1:0]         epoch_reg, right_reg, wrong_reg;
    res_t                     res_reg;

    logic [IW-1:0]            w_idx;
    feat_t                    x_rd;
    wt_t                      w_rd;
    logic signed [SHR_W-1:0]  acc_shr;
    wt_t                      tot;
    wt_t                      guess_next, err_next;
    logic signed [STEP_W-1:0] step;
    wt_t                      w_upd;
    logic                     refuse;
    logic                     load_w;
    res_t                     res_next;
    logic [CNT_W-1:0]         epoch_next, right_next, wrong_next, right_inc, wrong_inc;

    assign w_idx = v2_reg ? i2_reg : idx;
    assign x_rd  = x_reg[idx];
    assign w_rd  = w_reg[w_idx];

    assign refuse      = (mode_reg == MODE_TRAIN) && (epoch_reg >= cfg.max_epochs);
    assign stat.mode   = mode_reg;
    assign stat.refuse = refuse;

    // activation
    assign acc_shr  = $signed(acc_reg[ACC_W-1:FRAC_BITS]);
    assign tot      = sat24(SAT_IN_W'(acc_shr) + SAT_IN_W'(cfg.bias));

    always_comb
    begin
        case (cfg.act_kind)
            ACT_LINEAR:   guess_next = tot;
            ACT_UNIPOLAR: guess_next = (!tot[WT_W-1] && tot != '0) ? ONE_Q14 : '0;
            default:      guess_next = (!tot[WT_W-1] && tot != '0) ? ONE_Q14 : -ONE_Q14;
        endcase
    end

    assign err_next = sat24(SAT_IN_W'(target_reg) - SAT_IN_W'(guess_next));

    // weight step, floor of the Q.44 product
    assign step  = $signed(p2_reg[P2_W-1:STEP_SHIFT]);
    assign w_upd = sat24(SAT_IN_W'(w_rd) + SAT_IN_W'(step));

    // result and tallies at the end of the item
    always_comb
    begin
        res_next   = '0;
        epoch_next = epoch_reg;
        right_next = right_reg;
        wrong_next = wrong_reg;
        right_inc  = right_reg;
        wrong_inc  = wrong_reg;
        load_w     = 1'b0;
        case (mode_reg)
            MODE_LOAD:
                load_w = 1'b1;
            MODE_TRAIN:
            begin
                if (refuse)
                    res_next.refused = 1'b1;
                else
                begin
                    res_next.guess   = guess_reg;
                    res_next.error   = err_reg;
                    res_next.correct = (err_reg == '0);
                    if (last_reg)
                        epoch_next = sat_inc(epoch_reg);
                end
            end
            MODE_VERIFY:
            begin
                res_next.guess   = guess_reg;
                res_next.error   = err_reg;
                res_next.correct = (err_reg == '0);
                if (err_reg == '0)
                    right_inc = sat_inc(right_reg);
                else
                    wrong_inc = sat_inc(wrong_reg);
                res_next.ccount = right_inc;
                res_next.wcount = wrong_inc;
                right_next      = last_reg ? '0 : right_inc;
                wrong_next      = last_reg ? '0 : wrong_inc;
            end
            default:
            begin
                res_next.guess   = guess_reg;
                res_next.error   = err_reg;
                res_next.correct = (err_reg == '0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FEATURES; i++)
                w_reg[i] <= '0;
            epoch_reg <= '0;
            right_reg <= '0;
            wrong_reg <= '0;
            pv_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.dot_issue;
            v1_reg <= cmd.upd_issue;
            v2_reg <= v1_reg;
            if (v2_reg)
                w_reg[i2_reg] <= w_upd;
            if (cmd.finish)
            begin
                epoch_reg <= epoch_next;
                right_reg <= right_next;
                wrong_reg <= wrong_next;
                if (load_w)
                begin
                    for (int i = 0; i < NUM_FEATURES; i++)
                        w_reg[i] <= WT_W'(x_reg[i]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode_t'(mode);
            last_reg   <= last_sample;
            target_reg <= target_value;
            for (int i = 0; i < NUM_FEATURES; i++)
                x_reg[i] <= feat_in[i];
            acc_reg    <= '0;
        end
        else if (pv_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (cmd.dot_issue)
            prod_reg <= x_rd * w_rd;
        if (cmd.act)
        begin
            guess_reg <= guess_next;
            err_reg   <= err_next;
        end
        if (cmd.upd_issue)
        begin
            p1_reg <= $signed(x_rd) * $signed({1'b0, cfg.lrate});
            i1_reg <= idx;
        end
        p2_reg <= err_reg * p1_reg;
        i2_reg <= i1_reg;
        if (cmd.finish)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

@@ rtl/core/perceptron_train_classify.sv @@
// Top level of the perceptron block: configuration, controller and datapath
//
//  channel   direction  handshake                      payload
//  in        to block   in_valid / in_ready            mode, feature_0..7, target_value,
//                                                      last_sample
//  out       from block out_valid / out_ready          guess_value, error_value, is_correct,
//                                                      correct_count, wrong_count, train_refused
//  apb       to block   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One item at a time. Load and refused train words skip the arithmetic; verify and classify do
// the dot product and activation; train adds the update. One multiplier walks the features for
// the dot product, then a two-multiplier chain walks them again for the weight update.
// Reset clears weights, epoch count, tallies and the registers to their defaults.
// A result held by out_ready stalls the block in its last step; the next word waits.
`include "perceptron_train_classify_defines.svh"
module perceptron_train_classify
    import ptc_pkg::*;
#(
    parameter int NUM_FEATURES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  feat_t              feature_0,
    input  feat_t              feature_1,
    input  feat_t              feature_2,
    input  feat_t              feature_3,
    input  feat_t              feature_4,
    input  feat_t              feature_5,
    input  feat_t              feature_6,
    input  feat_t              feature_7,
    input  feat_t              target_value,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output wt_t                guess_value,
    output wt_t                error_value,
    output logic               is_correct,
    output logic [CNT_W-1:0]   correct_count,
    output logic [CNT_W-1:0]   wrong_count,
    output logic               train_refused
);

    localparam int IW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    cfg_t          cfg;
    cmd_t          cmd;
    stat_t         stat;
    res_t          res;
    logic [IW-1:0] idx;
    feat_vec_t     feat_in;

    assign pready     = 1'b1;
    assign feat_in[0] = feature_0;
    assign feat_in[1] = feature_1;
    assign feat_in[2] = feature_2;
    assign feat_in[3] = feature_3;
    assign feat_in[4] = feature_4;
    assign feat_in[5] = feature_5;
    assign feat_in[6] = feature_6;
    assign feat_in[7] = feature_7;

    ptc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ptc_ctrl #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .idx       (idx)
    );

    ptc_dpath #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .idx          (idx),
        .mode         (mode),
        .feat_in      (feat_in),
        .target_value (target_value),
        .last_sample  (last_sample),
        .stat         (stat),
        .res          (res)
    );

    assign guess_value   = res.guess;
    assign error_value   = res.error;
    assign is_correct    = res.correct;
    assign correct_count = res.ccount;
    assign wrong_count   = res.wcount;
    assign train_refused = res.refused;

    `PTC_ASSERT_IMPL(a_no_result_overwrite, cmd.finish, !out_valid || out_ready)
    `PTC_ASSERT_IMPL(a_refused_word_zero, out_valid && train_refused,
        guess_value == '0 && error_value == '0 && !is_correct &&
        correct_count == '0 && wrong_count == '0)
    `PTC_ASSERT_IMPL(a_update_only_train, cmd.upd_issue,
        stat.mode == MODE_TRAIN && !stat.refuse)
    `PTC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

@@ test/tb_perceptron_train_classify.sv @@
// Self-checking testbench for the perceptron block: directed table, then randomized passes
module tb_perceptron_train_classify;
    import ptc_pkg::*;

    localparam logic [1:0] ACT_BIPOLAR     = 2'd2;
    localparam logic [1:0] ACT_BIPOLAR_ALT = 2'd3;
    localparam wt_t        WT_TOP          = 24'sh7FFFFF;
    localparam wt_t        WT_BOTTOM       = 24'sh800000;
    localparam feat_t      FEAT_TOP        = 16'sh4000;
    localparam feat_t      FEAT_BOTTOM     = 16'shC000;
    localparam int         PHASES          = 12;
    localparam int         WORDS_PER_PHASE = 160;
    localparam int         MAX_REPORTS     = 100;

    typedef struct packed {
        mode_t           mode;
        feat_t [7:0]     feat;
        feat_t           target;
        logic            is_last;
    } word_t;

    typedef struct packed {
        word_t w;
        logic  typed;
        res_t  want;
    } row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic             pready;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       mode = 2'd0;
    feat_t            feature_0 = '0;
    feat_t            feature_1 = '0;
    feat_t            feature_2 = '0;
    feat_t            feature_3 = '0;
    feat_t            feature_4 = '0;
    feat_t            feature_5 = '0;
    feat_t            feature_6 = '0;
    feat_t            feature_7 = '0;
    feat_t            target_value = '0;
    logic             last_sample = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    wt_t              guess_value;
    wt_t              error_value;
    logic             is_correct;
    logic [CNT_W-1:0] correct_count;
    logic [CNT_W-1:0] wrong_count;
    logic             train_refused;

    // predictor state
    cfg_t             cfg = '{RST_ACT_KIND, RST_BIAS, RST_LRATE, RST_MAX_EPOCHS};
    wt_t              weights [8];
    logic [CNT_W-1:0] epochs = '0;
    logic [CNT_W-1:0] right_n = '0;
    logic [CNT_W-1:0] wrong_n = '0;

    res_t             due_scores [$];
    row_t             script [$];
    int               mismatches = 0;
    int               stall_left = 0;
    bit               send_idle = 1'b1;
    bit               sink_idle = 1'b1;

    perceptron_train_classify i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .feature_0     (feature_0),
        .feature_1     (feature_1),
        .feature_2     (feature_2),
        .feature_3     (feature_3),
        .feature_4     (feature_4),
        .feature_5     (feature_5),
        .feature_6     (feature_6),
        .feature_7     (feature_7),
        .target_value  (target_value),
        .last_sample   (last_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .guess_value   (guess_value),
        .error_value   (error_value),
        .is_correct    (is_correct),
        .correct_count (correct_count),
        .wrong_count   (wrong_count),
        .train_refused (train_refused)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            if (mismatches < MAX_REPORTS)
                $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
            mismatches++;
        end
    endtask

    function automatic wt_t clip24(input longint x);
        wt_t r;
        if (x > longint'(WT_TOP))
            r = WT_TOP;
        else if (x < longint'(WT_BOTTOM))
            r = WT_BOTTOM;
        else
            r = x[23:0];
        return r;
    endfunction

    function automatic res_t score_word(input word_t w);
        res_t   r;
        longint acc;
        longint g;
        longint step;
        wt_t    tot;
        wt_t    e;
        r = '0;
        acc = 0;
        if (w.mode == MODE_LOAD)
        begin
            for (int i = 0; i < 8; i++)
                weights[i] = clip24(longint'($signed(w.feat[i])));
        end
        else if (w.mode == MODE_TRAIN && epochs >= cfg.max_epochs)
            r.refused = 1'b1;
        else
        begin
            for (int i = 0; i < 8; i++)
                acc += longint'($signed(w.feat[i])) * longint'($signed(weights[i]));
            tot = clip24((acc >>> FRAC_BITS) + longint'($signed(cfg.bias)));
            if (cfg.act_kind[1])
                g = (tot > 0) ? longint'(ONE_Q14) : -longint'(ONE_Q14);
            else if (cfg.act_kind[0])
                g = (tot > 0) ? longint'(ONE_Q14) : 0;
            else
                g = longint'(tot);
            e = clip24(longint'($signed(w.target)) - g);
            r.guess = g[23:0];
            r.error = e;
            r.correct = (e == 0);
            if (w.mode == MODE_TRAIN)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    step = longint'(e) * longint'($signed(w.feat[i])) * longint'(cfg.lrate);
                    weights[i] = clip24(longint'(weights[i]) + (step >>> STEP_SHIFT));
                end
                if (w.is_last && epochs != CNT_MAX)
                    epochs++;
            end
            else if (w.mode == MODE_VERIFY)
            begin
                if (r.correct)
                begin
                    if (right_n != CNT_MAX)
                        right_n++;
                end
                else if (wrong_n != CNT_MAX)
                    wrong_n++;
                r.ccount = right_n;
                r.wcount = wrong_n;
                if (w.is_last)
                begin
                    right_n = '0;
                    wrong_n = '0;
                end
            end
        end
        return r;
    endfunction

    function automatic feat_t rand_feat();
        int    v;
        feat_t f;
        case ($urandom_range(0, 7))
            0: v = -16384;
            1: v = 16384;
            2: v = 0;
            3: v = int'($urandom_range(0, 16)) - 8;
            default: v = int'($urandom_range(0, 32768)) - 16384;
        endcase
        f = v[15:0];
        return f;
    endfunction

    function automatic feat_t rand_target();
        feat_t f;
        case ($urandom_range(0, 3))
            0: f = FEAT_BOTTOM;
            1: f = '0;
            2: f = FEAT_TOP;
            default: f = rand_feat();
        endcase
        return f;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        case (idx)
            REG_ACT_KIND: mask = 32'h3;
            REG_BIAS:     mask = 32'hFFFFFF;
            default:      mask = 32'hFFFF;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ACT_KIND:   cfg.act_kind = value[1:0];
            REG_BIAS:       cfg.bias = value[23:0];
            REG_LRATE:      cfg.lrate = value[15:0];
            REG_MAX_EPOCHS: cfg.max_epochs = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        flag_mismatch("register readback", readback & mask, value & mask);
        @(posedge clk);
    endtask

    task automatic send_word(input word_t w, input bit typed, input res_t want);
        res_t predicted;
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        mode <= w.mode;
        feature_0 <= w.feat[0];
        feature_1 <= w.feat[1];
        feature_2 <= w.feat[2];
        feature_3 <= w.feat[3];
        feature_4 <= w.feat[4];
        feature_5 <= w.feat[5];
        feature_6 <= w.feat[6];
        feature_7 <= w.feat[7];
        target_value <= w.target;
        last_sample <= w.is_last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = score_word(w);
        due_scores.push_back(typed ? want : predicted);
    endtask

    task automatic add_row(input mode_t m, input int a, input int b, input int tgt,
                           input bit is_last, input bit typed, input int g, input int e,
                           input bit ok, input int cc, input int wc);
        row_t r;
        r = '0;
        r.w.mode = m;
        for (int i = 0; i < 8; i++)
            r.w.feat[i] = (i % 2 == 0) ? a[15:0] : b[15:0];
        r.w.target = tgt[15:0];
        r.w.is_last = is_last;
        r.typed = typed;
        r.want.guess = g[23:0];
        r.want.error = e[23:0];
        r.want.correct = ok;
        r.want.ccount = cc[15:0];
        r.want.wcount = wc[15:0];
        script.push_back(r);
    endtask

    task automatic drain_scores();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_scores.size() != 0);
    endtask

    task automatic run_words(input int count, input bit pause_midway);
        word_t w;
        int    sent;
        int    kind;
        int    burst;
        bit    pause_pending;
        sent = 0;
        pause_pending = pause_midway;
        while (sent < count)
        begin
            if (pause_pending && sent >= count / 2)
            begin
                pause_pending = 1'b0;
                drain_scores();
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6)
                burst = $urandom_range(1, 6);
            else if (kind == 8)
                burst = $urandom_range(1, 3);
            else
                burst = 1;
            for (int b = 0; b < burst; b++)
            begin
                if (kind <= 4)
                    w.mode = MODE_TRAIN;
                else if (kind <= 6)
                    w.mode = MODE_VERIFY;
                else if (kind == 7)
                    w.mode = MODE_LOAD;
                else if (kind == 8)
                    w.mode = MODE_CLASSIFY;
                else
                    w.mode = mode_t'($urandom_range(0, 3));
                for (int i = 0; i < 8; i++)
                    w.feat[i] = rand_feat();
                w.target = rand_target();
                if (kind <= 6)
                    w.is_last = (b == burst - 1);
                else
                    w.is_last = 1'($urandom_range(0, 1));
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // hold the result channel in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_scores.size() == 0)
                flag_mismatch("word with nothing due", {8'b0, guess_value}, 32'hFFFFFFFF);
            else
            begin
                flag_mismatch("guess_value", {8'b0, guess_value}, {8'b0, due_scores[0].guess});
                flag_mismatch("error_value", {8'b0, error_value}, {8'b0, due_scores[0].error});
                flag_mismatch("is_correct", {31'b0, is_correct}, {31'b0, due_scores[0].correct});
                flag_mismatch("correct_count", {16'b0, correct_count},
                              {16'b0, due_scores[0].ccount});
                flag_mismatch("wrong_count", {16'b0, wrong_count},
                              {16'b0, due_scores[0].wcount});
                flag_mismatch("train_refused", {31'b0, train_refused},
                              {31'b0, due_scores[0].refused});
                void'(due_scores.pop_front());
            end
        end
    end

    initial
    begin
        logic [1:0]       act;
        wt_t              bias;
        logic [15:0]      lr;
        logic [15:0]      epoch_cap;
        int               tmp;
        for (int i = 0; i < 8; i++)
            weights[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // weights are zero and the hard limit is unipolar right after reset
        add_row(MODE_CLASSIFY, 16384, 16384, 16384, 0, 1, 0, 16384, 0, 0, 0);
        add_row(MODE_VERIFY, -16384, -16384, 0, 0, 1, 0, 0, 1, 1, 0);
        add_row(MODE_VERIFY, 16384, -1, -16384, 1, 1, 0, -16384, 0, 1, 1);
        add_row(MODE_VERIFY, 0, 0, 0, 1, 1, 0, 0, 1, 1, 0);
        add_row(MODE_TRAIN, 16384, 16384, 16384, 0, 1, 0, 16384, 0, 0, 0);
        add_row(MODE_TRAIN, -16384, 16384, -16384, 1, 0, 0, 0, 0, 0, 0);
        add_row(MODE_CLASSIFY, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 16384, 16384, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(MODE_CLASSIFY, 16384, 16384, 16384, 0, 1, 16384, 0, 1, 0, 0);
        add_row(MODE_CLASSIFY, -16384, -16384, 0, 1, 1, 0, 0, 1, 0, 0);
        add_row(MODE_VERIFY, -16384, -16384, 16384, 0, 1, 0, 16384, 0, 0, 1);
        add_row(MODE_VERIFY, 16384, 16384, 16384, 1, 1, 16384, 0, 1, 1, 1);
        add_row(MODE_LOAD, -16384, 16384, 0, 1, 1, 0, 0, 0, 0, 0);
        add_row(MODE_CLASSIFY, 16384, 16384, -16384, 0, 1, 0, -16384, 0, 0, 0);
        add_row(MODE_TRAIN, 0, -16384, -16384, 1, 0, 0, 0, 0, 0, 0);
        add_row(MODE_TRAIN, -1, 1, 16383, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 16384, -16384, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(MODE_CLASSIFY, -16384, -1, 16384, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_TRAIN, 16384, 16384, -16384, 1, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        foreach (script[k])
            send_word(script[k].w, script[k].typed, script[k].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_scores();
            repeat (4) @(posedge clk);
            case (ph)
                0:
                begin
                    act = ACT_LINEAR;
                    bias = '0;
                    lr = 16'hFFFF;
                    epoch_cap = 16'hFFFF;
                end
                1:
                begin
                    act = ACT_BIPOLAR;
                    bias = WT_BOTTOM;
                    lr = 16'h0000;
                    epoch_cap = 16'd1;
                end
                2:
                begin
                    act = ACT_BIPOLAR_ALT;
                    bias = WT_TOP;
                    lr = RST_LRATE;
                    epoch_cap = 16'd0;
                end
                3:
                begin
                    act = ACT_LINEAR;
                    bias = WT_BOTTOM;
                    lr = 16'hFFFF;
                    epoch_cap = epochs + 16'd2;
                end
                default:
                begin
                    act = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 5))
                        0: bias = WT_TOP;
                        1: bias = WT_BOTTOM;
                        default:
                        begin
                            tmp = int'($urandom_range(0, 65536)) - 32768;
                            bias = tmp[23:0];
                        end
                    endcase
                    lr = 16'($urandom_range(0, 65535));
                    tmp = int'(epochs) + int'($urandom_range(0, 12));
                    epoch_cap = (tmp > 65535) ? 16'hFFFF : tmp[15:0];
                end
            endcase
            write_reg(REG_ACT_KIND, {30'b0, act});
            write_reg(REG_BIAS, {{8{bias[23]}}, bias});
            write_reg(REG_LRATE, {16'b0, lr});
            write_reg(REG_MAX_EPOCHS, {16'b0, epoch_cap});
            send_idle = (ph != 4 && ph != PHASES - 1);
            sink_idle = send_idle;
            run_words(WORDS_PER_PHASE, ph == 6);
        end

        drain_scores();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
